// File: design/ftprc_pkg.sv
package ftprc_pkg;

	// received byte codes
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	localparam int unsigned NUM_DIGITS = 3;

	localparam logic [2:0] CNT_FULL = 3'd3;
	localparam logic [2:0] CNT_SAT  = 3'd4;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_BAD  = 1'b1;

	typedef enum logic [1:0] {
		PH_COLLECT = 2'd0,
		PH_FINAL   = 2'd1,
		PH_MATCH   = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic [2:0]             digit_count;
		logic [NUM_DIGITS-1:0][3:0] code_digits;
	} parse_state_t;

	typedef struct packed {
		logic       emit;
		logic [9:0] reply_code;
		logic [3:0] reply_class;
		logic       status;
	} parse_result_t;

endpackage

// File: design/ftprc_step.sv
module ftprc_step (
	input  logic [7:0]              rx_byte,
	input  ftprc_pkg::parse_state_t cur,
	output ftprc_pkg::parse_state_t nxt,
	output ftprc_pkg::parse_result_t res
);

	logic        is_digit;
	logic [1:0]  match_idx;
	logic [7:0]  expect_byte;
	logic [9:0]  code_val;

	assign is_digit    = (rx_byte >= ftprc_pkg::CH_ZERO) && (rx_byte <= ftprc_pkg::CH_NINE);
	assign match_idx   = cur.digit_count[1:0];
	assign expect_byte = ftprc_pkg::CH_ZERO + {4'd0, cur.code_digits[match_idx]};
	assign code_val    = {6'd0, cur.code_digits[0]} * 10'd100
	                   + {6'd0, cur.code_digits[1]} * 10'd10
	                   + {6'd0, cur.code_digits[2]};

	// next state
	always_comb begin
		nxt = cur;
		case (cur.phase)
			ftprc_pkg::PH_FINAL: begin
				if (rx_byte == ftprc_pkg::CH_NEWLINE) begin
					nxt.phase       = ftprc_pkg::PH_COLLECT;
					nxt.digit_count = 3'd0;
				end
			end
			ftprc_pkg::PH_MATCH: begin
				if (cur.digit_count < ftprc_pkg::CNT_FULL) begin
					if (rx_byte == expect_byte) begin
						nxt.digit_count = cur.digit_count + 3'd1;
					end
				end else if (rx_byte == ftprc_pkg::CH_SPACE) begin
					nxt.phase = ftprc_pkg::PH_FINAL;
				end else if (rx_byte == ftprc_pkg::CH_DASH) begin
					nxt.digit_count = 3'd0;
				end
			end
			default: begin
				// collecting digits; unused phase code behaves the same
				nxt.phase = ftprc_pkg::PH_COLLECT;
				if (rx_byte == ftprc_pkg::CH_SPACE) begin
					nxt.digit_count = 3'd0;
					if (cur.digit_count == ftprc_pkg::CNT_FULL) begin
						nxt.phase = ftprc_pkg::PH_FINAL;
					end
				end else if (rx_byte == ftprc_pkg::CH_DASH) begin
					nxt.digit_count = 3'd0;
					nxt.phase       = ftprc_pkg::PH_MATCH;
				end else if (is_digit) begin
					if (cur.digit_count < ftprc_pkg::CNT_FULL) begin
						nxt.code_digits[match_idx] = rx_byte[3:0];
					end
					if (cur.digit_count < ftprc_pkg::CNT_SAT) begin
						nxt.digit_count = cur.digit_count + 3'd1;
					end
				end
			end
		endcase
	end

	// result
	always_comb begin
		res.emit        = 1'b0;
		res.reply_code  = 10'd0;
		res.reply_class = 4'd0;
		res.status      = ftprc_pkg::STATUS_DONE;
		case (cur.phase)
			ftprc_pkg::PH_FINAL: begin
				if (rx_byte == ftprc_pkg::CH_NEWLINE) begin
					res.emit        = 1'b1;
					res.reply_code  = code_val;
					res.reply_class = cur.code_digits[0];
				end
			end
			ftprc_pkg::PH_MATCH: begin
				res.emit = 1'b0;
			end
			default: begin
				if ((rx_byte == ftprc_pkg::CH_SPACE) &&
				    (cur.digit_count != ftprc_pkg::CNT_FULL)) begin
					res.emit   = 1'b1;
					res.status = ftprc_pkg::STATUS_BAD;
				end
			end
		endcase
	end

endmodule

// File: design/ftp_reply_code_parser_core.sv
// channel | direction | handshake          | payload
// rx      | in        | rx_valid/rx_stall  | rx_byte[7:0]
// res     | out       | res_valid/res_stall| reply_code[9:0], reply_class[3:0], status
//
// one word per cycle while the result side does not stall; a taken byte goes through the
// input register, then the parse logic, into the result register
// arst_n clears the parse state to "collecting digits, no digits seen"
// a held result stalls the parse stage only; rx_stall rises once the input
// register is also full and the result has not been taken
module ftp_reply_code_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [9:0] reply_code,
	output logic [3:0] reply_class,
	output logic       status
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parse state
	ftprc_pkg::parse_state_t state_q;
	ftprc_pkg::parse_state_t state_nxt;
	ftprc_pkg::parse_result_t step_res;

	// result register
	logic       res_valid_q;
	logic [9:0] reply_code_q;
	logic [3:0] reply_class_q;
	logic       status_q;

	logic out_free;
	logic advance;
	logic rx_take;

	// result slot can be written when empty or being drained this cycle
	assign out_free = !res_valid_q || !res_stall;
	assign advance  = valid_s1 && out_free;
	assign rx_stall = valid_s1 && !out_free;
	assign rx_take  = rx_valid && !rx_stall;

	ftprc_step u_step (
		.rx_byte (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx_byte;
		end
	end

	// parse state moves only when the buffered byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= ftprc_pkg::PH_COLLECT;
			state_q.digit_count <= 3'd0;
			state_q.code_digits <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= advance && step_res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.emit) begin
			reply_code_q  <= step_res.reply_code;
			reply_class_q <= step_res.reply_class;
			status_q      <= step_res.status;
		end
	end

	assign res_valid   = res_valid_q;
	assign reply_code  = reply_code_q;
	assign reply_class = reply_class_q;
	assign status      = status_q;

endmodule

// File: bench/ftprc_checker.sv
module ftprc_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic       res_valid,
	input  logic       res_stall,
	input  logic [9:0] reply_code,
	input  logic [3:0] reply_class,
	input  logic       status,
	output int         fails,
	output int         pending
);

	typedef struct packed {
		logic [9:0] code;
		logic [3:0] cls;
		logic       status;
	} reply_t;

	reply_t              expected_replies [$];
	ftprc_pkg::phase_t   ph;
	logic [2:0]          cnt;
	logic [3:0]          digits [3];
	reply_t              want;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		fails++;
	endtask

	task automatic push_reply(input logic [9:0] code, input logic [3:0] cls, input logic st);
		reply_t r;
		r.code = code;
		r.cls = cls;
		r.status = st;
		expected_replies.push_back(r);
		ph = ftprc_pkg::PH_COLLECT;
		cnt = '0;
	endtask

	// next parser state and any finished reply for one received word
	task automatic parse_reply_byte(input logic [7:0] c);
		logic [7:0] val;
		logic [9:0] code;
		case (ph)
		ftprc_pkg::PH_FINAL: begin
			if (c == ftprc_pkg::CH_NEWLINE) begin
				code = {6'd0, digits[0]} * 10'd100 + {6'd0, digits[1]} * 10'd10
					+ {6'd0, digits[2]};
				push_reply(code, digits[0], ftprc_pkg::STATUS_DONE);
			end
		end
		ftprc_pkg::PH_MATCH: begin
			if (cnt < ftprc_pkg::CNT_FULL) begin
				if (c == ftprc_pkg::CH_ZERO + {4'd0, digits[cnt[1:0]]})
					cnt = cnt + 3'd1;
			end else if (c == ftprc_pkg::CH_SPACE) begin
				ph = ftprc_pkg::PH_FINAL;
			end else if (c == ftprc_pkg::CH_DASH) begin
				cnt = '0;
			end
		end
		default: begin
			ph = ftprc_pkg::PH_COLLECT;
			if (c == ftprc_pkg::CH_SPACE) begin
				if (cnt != ftprc_pkg::CNT_FULL) begin
					push_reply('0, '0, ftprc_pkg::STATUS_BAD);
				end else begin
					cnt = '0;
					ph = ftprc_pkg::PH_FINAL;
				end
			end else if (c == ftprc_pkg::CH_DASH) begin
				cnt = '0;
				ph = ftprc_pkg::PH_MATCH;
			end else if (c >= ftprc_pkg::CH_ZERO && c <= ftprc_pkg::CH_NINE) begin
				val = c - ftprc_pkg::CH_ZERO;
				if (cnt < ftprc_pkg::CNT_FULL)
					digits[cnt[1:0]] = val[3:0];
				if (cnt < ftprc_pkg::CNT_SAT)
					cnt = cnt + 3'd1;
			end
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = ftprc_pkg::PH_COLLECT;
			cnt = '0;
			for (int i = 0; i < 3; i++)
				digits[i] = '0;
			expected_replies.delete();
			fails = 0;
			pending = 0;
		end else begin
			// results leave only after their word has passed the input and result registers, so check before predicting
			if (res_valid && !res_stall) begin
				if (expected_replies.size() == 0) begin
					report_mismatch($sformatf("unexpected reply: code %0d class %0d status %0d",
						reply_code, reply_class, status));
				end else begin
					want = expected_replies.pop_front();
					if (reply_code !== want.code)
						report_mismatch($sformatf("reply_code %0d, expected %0d",
							reply_code, want.code));
					if (reply_class !== want.cls)
						report_mismatch($sformatf("reply_class %0d, expected %0d",
							reply_class, want.cls));
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.status));
				end
			end
			if (rx_valid && !rx_stall)
				parse_reply_byte(rx_byte);
			pending = expected_replies.size();
		end
	end

endmodule

// File: bench/tb_top.sv
module tb_top;

	// run bounds: LIMIT covers the worst word, a long send gap plus a long result
	// stall, for every word of the run, several times over
	localparam int ITEMS = 750;
	localparam int LIMIT = 1_000_000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [9:0] reply_code;
	logic [3:0] reply_class;
	logic       status;

	int         fails;
	int         pending;
	int         cycles = 0;
	int         n_items = 0;
	int         kind;
	bit         calm = 1'b0;      // both sides run without idling while set
	bit         mid_drain = 1'b0;
	logic [3:0] reply_digits [3]; // code of the reply being built

	ftp_reply_code_parser_core dut (
		.clk,
		.arst_n,
		.rx_valid,
		.rx_stall,
		.rx_byte,
		.res_valid,
		.res_stall,
		.reply_code,
		.reply_class,
		.status
	);

	ftprc_checker chk (
		.clk,
		.arst_n,
		.rx_valid,
		.rx_stall,
		.rx_byte,
		.res_valid,
		.res_stall,
		.reply_code,
		.reply_class,
		.status,
		.fails,
		.pending
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the handshake hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// idle stretch length: mostly short, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// filler text: mostly letters and punctuation, sometimes any printable
	function automatic logic [7:0] text_char();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(8'h20, 8'h7E));
		return 8'($urandom_range(8'h41, 8'h7E));
	endfunction

	// result side: random stall runs, released entirely in calm stretches
	initial begin
		@(negedge clk);
		forever begin
			if (calm) begin
				res_stall <= 1'b0;
				@(negedge clk);
			end else begin
				res_stall <= ($urandom_range(0, 2) == 0);
				repeat (idle_len()) @(negedge clk);
			end
		end
	end

	// one word on rx; entered and left at a falling edge, valid is lowered
	// only when a gap comes, so it never drops and rises in one step
	task automatic drive_byte(input logic [7:0] b);
		int gap;
		gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		@(negedge clk);
	endtask

	// a word that steers the parser, counted toward the run length
	task automatic send_byte(input logic [7:0] b);
		drive_byte(b);
		n_items++;
	endtask

	task automatic send_digit(input logic [3:0] d);
		send_byte(ftprc_pkg::CH_ZERO + {4'd0, d});
	endtask

	// filler on a text line, not counted
	task automatic send_text(input int n);
		repeat (n) drive_byte(text_char());
	endtask

	// leading digits of the current code
	task automatic send_code(input int upto);
		for (int i = 0; i < upto; i++)
			send_digit(reply_digits[i]);
	endtask

	// code, space, text, newline: a whole single-line reply or the last line
	// of a multi-line one
	task automatic send_last_line();
		send_code(ftprc_pkg::NUM_DIGITS);
		send_byte(ftprc_pkg::CH_SPACE);
		send_text($urandom_range(0, 3));
		send_byte(ftprc_pkg::CH_NEWLINE);
	endtask

	// code with a dash, some continuation lines, then the last line
	task automatic multi_line();
		send_code(ftprc_pkg::NUM_DIGITS);
		send_byte(ftprc_pkg::CH_DASH);
		send_text($urandom_range(0, 3));
		send_byte(ftprc_pkg::CH_NEWLINE);
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 2))
			0: begin
				// plain text line
				send_text($urandom_range(0, 4));
			end
			1: begin
				// full code plus dash restarts the match
				send_code(ftprc_pkg::NUM_DIGITS);
				send_byte(ftprc_pkg::CH_DASH);
				send_text($urandom_range(0, 3));
			end
			default: begin
				// only part of the code, match position is kept
				send_code($urandom_range(1, 2));
				send_text($urandom_range(0, 3));
			end
			endcase
			send_byte(ftprc_pkg::CH_NEWLINE);
		end
		send_last_line();
	endtask

	// wrong digit count before a space, or a dash after too few digits
	// followed by a tail of digits and delimiters
	task automatic malformed();
		int n;
		n = $urandom_range(0, 5);
		if (n == 3)
			n = 4 + $urandom_range(0, 2);
		for (int i = 0; i < n; i++)
			send_digit(i < 3 ? reply_digits[i] : 4'($urandom_range(0, 9)));
		if (n < 3 && $urandom_range(0, 1) == 1) begin
			send_byte(ftprc_pkg::CH_DASH);
			repeat ($urandom_range(3, 8)) begin
				case ($urandom_range(0, 12))
				10: send_byte(ftprc_pkg::CH_SPACE);
				11: send_byte(ftprc_pkg::CH_DASH);
				12: send_byte(ftprc_pkg::CH_NEWLINE);
				default: send_digit(4'($urandom_range(0, 9)));
				endcase
			end
		end else begin
			send_byte(ftprc_pkg::CH_SPACE);
		end
	endtask

	// hold the sender until every predicted reply is out, then let the pipe settle
	task automatic wait_for_results();
		rx_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		// null byte is ignored, a space with no digits is an error
		send_byte(8'h00);
		send_byte(ftprc_pkg::CH_SPACE);
		// dash with no digits matches the reset store "000", reply 000
		send_byte(ftprc_pkg::CH_DASH);
		send_digit(4'd0);
		send_digit(4'd0);
		send_digit(4'd0);
		send_byte(ftprc_pkg::CH_SPACE);
		send_byte(ftprc_pkg::CH_NEWLINE);
		// fourth digit saturates the count, the space reports an error
		send_digit(4'd9);
		send_digit(4'd9);
		send_digit(4'd9);
		send_digit(4'd9);
		send_byte(ftprc_pkg::CH_SPACE);
		// two digits then dash: store becomes 2,1,9; 0xff is a mismatch,
		// a digit after a full match does nothing, dash restarts, reply 219
		send_digit(4'd2);
		send_digit(4'd1);
		send_byte(ftprc_pkg::CH_DASH);
		send_byte(8'hFF);
		send_digit(4'd2);
		send_digit(4'd1);
		send_digit(4'd9);
		send_digit(4'd9);
		send_byte(ftprc_pkg::CH_DASH);
		send_digit(4'd2);
		send_digit(4'd1);
		send_digit(4'd9);
		send_byte(ftprc_pkg::CH_SPACE);
		send_byte(ftprc_pkg::CH_NEWLINE);
		wait_for_results();

		// random part: mostly well-formed replies with random codes and text,
		// the rest broken replies and raw noise over the whole byte range
		n_items = 0;
		while (n_items < ITEMS) begin
			calm = ($urandom_range(0, 5) == 0);
			for (int i = 0; i < 3; i++)
				reply_digits[i] = 4'($urandom_range(0, 9));
			kind = $urandom_range(0, 99);
			if (kind < 40)
				send_last_line();
			else if (kind < 70)
				multi_line();
			else if (kind < 85)
				malformed();
			else
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
			// one full drain halfway through
			if (!mid_drain && n_items >= ITEMS / 2) begin
				wait_for_results();
				mid_drain = 1'b1;
			end
		end

		wait_for_results();
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
design/ftprc_pkg.sv
design/ftprc_step.sv
design/ftp_reply_code_parser_core.sv
bench/ftprc_checker.sv
bench/tb_top.sv
